// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the sparse matrix-vector block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk_sig, rstn_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk_sig, rstn_sig, expr, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(expr)) else $error(msg);

`endif

// ----- rtl/csc_mv_pkg.sv -----
// Package with the types, codes and constants of the sparse matrix-vector block.
`timescale 1ns / 1ps
package csc_mv_pkg;

  localparam int MAX_DIM  = 1024;
  localparam int ADDR_W   = $clog2(MAX_DIM);
  localparam int FIELD_W  = 10;
  localparam int VAL_W    = 32;
  localparam int ACC_W    = 48;
  localparam int FRAC_W   = 16;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_NZ   = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VEC,
    ST_MUL,
    ST_ACC,
    ST_RD,
    ST_RDOUT
  } state_t;

  typedef struct packed {
    op_t                       opcode;
    logic [FIELD_W-1:0]        index;
    logic [FIELD_W-1:0]        row;
    logic [FIELD_W-1:0]        col;
    logic signed [VAL_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0]        out_index;
    logic signed [ACC_W-1:0]   out_value;
  } out_item_t;

  // True when an index field addresses an entry of the stores.
  function automatic logic in_range(input logic [FIELD_W-1:0] v);
    return 32'(v) < 32'(MAX_DIM);
  endfunction

endpackage

// ----- rtl/csc_mv_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module csc_mv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sparse_csc_matvec_accumulate.sv -----
// Top level of the sparse matrix-vector multiply-accumulate block.
// A read word gives its result on out_strobe in ST_RDOUT, the state after ST_RD.
// A load or no-op word never holds the block busy; a read holds it through ST_RD and ST_RDOUT
// and an in-range nonzero through ST_VEC, ST_MUL and ST_ACC, set by the read-multiply-accumulate-write
// sequence over the two memories. Reset (rst_n low, synchronous) clears the mode register and
// starts a clearing pass over all 1024 accumulator entries, during which busy is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sparse_csc_matvec_accumulate (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  csc_mv_pkg::in_item_t   in_item,
  output logic                   out_strobe,
  output csc_mv_pkg::out_item_t  out_item,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wdata
);

  import csc_mv_pkg::*;

  // Sequencer state and the word being worked on.
  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  in_item_t                 item_r;
  logic                     transpose_r;
  logic signed [ACC_W-1:0]  prod_r;

  logic                     accept;
  logic                     nz_ok;
  logic                     idx_ok;
  logic [FIELD_W-1:0]       vec_sel;
  logic [FIELD_W-1:0]       dst_sel;

  // Memory ports.
  logic                     vec_we;
  logic [ADDR_W-1:0]        vec_waddr;
  logic [VAL_W-1:0]         vec_wdata;
  logic [ADDR_W-1:0]        vec_raddr;
  logic [VAL_W-1:0]         vec_rdata;
  logic                     acc_we;
  logic [ADDR_W-1:0]        acc_waddr;
  logic [ACC_W-1:0]         acc_wdata;
  logic [ADDR_W-1:0]        acc_raddr;
  logic [ACC_W-1:0]         acc_rdata;

  logic signed [2*VAL_W-1:0] full_prod;
  logic signed [ACC_W:0]     sum_w;
  logic signed [ACC_W-1:0]   sat_sum;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // In normal mode a nonzero reads the vector at its column and accumulates into its
  // row; in transpose mode the two roles swap.
  assign vec_sel = transpose_r ? item_r.row : item_r.col;
  assign dst_sel = transpose_r ? item_r.col : item_r.row;
  assign nz_ok   = in_range(in_item.row) && in_range(in_item.col);
  assign idx_ok  = in_range(item_r.index);

  // Loads are written straight from the input port in the cycle they are accepted,
  // so they never hold the block busy.
  assign vec_we    = accept && (in_item.opcode == OP_LOAD) && in_range(in_item.index);
  assign vec_waddr = in_item.index[ADDR_W-1:0];
  assign vec_wdata = in_item.value;
  assign vec_raddr = vec_sel[ADDR_W-1:0];

  // The accumulator read address follows the held word, so the registered read data
  // stays valid for as long as the word is in flight.
  assign acc_raddr = (item_r.opcode == OP_READ) ? item_r.index[ADDR_W-1:0]
                                                : dst_sel[ADDR_W-1:0];

  csc_mv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_DIM)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (vec_wdata),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  csc_mv_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_DIM)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // Q16.16 times Q16.16 gives Q32.32; dropping the low 16 bits rounds toward
  // minus infinity and leaves a Q32.16 value that always fits in 48 bits.
  assign full_prod = $signed(item_r.value) * $signed(vec_rdata);

  // One bit of headroom shows overflow, which then saturates.
  assign sum_w = {acc_rdata[ACC_W-1], acc_rdata} + {prod_r[ACC_W-1], prod_r};
  always_comb begin
    if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      sat_sum = sum_w[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_sum = sum_w[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      transpose_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_wr_en) begin
        transpose_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (state_r == ST_MUL) begin
      prod_r <= full_prod[2*VAL_W-1:FRAC_W];
    end
  end

  always_comb begin
    state_nxt          = state_r;
    clr_cnt_nxt        = clr_cnt_r;
    acc_we             = 1'b0;
    acc_waddr          = acc_raddr;
    acc_wdata          = '0;
    out_strobe         = 1'b0;
    out_item.out_index = item_r.index;
    out_item.out_value = idx_ok ? $signed(acc_rdata) : '0;
    unique case (state_r)
      ST_CLEAR: begin
        // Sweep the accumulator memory to zero, one entry a cycle.
        acc_we      = 1'b1;
        acc_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(MAX_DIM - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_item.opcode == OP_NZ && nz_ok) begin
            state_nxt = ST_VEC;
          end else if (in_item.opcode == OP_READ) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_VEC: begin
        // Vector and accumulator reads are issued together.
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_we    = 1'b1;
        acc_wdata = sat_sum;
        state_nxt = ST_IDLE;
      end
      ST_RD: begin
        state_nxt = ST_RDOUT;
      end
      ST_RDOUT: begin
        // Return the entry and clear it behind the read.
        out_strobe = 1'b1;
        acc_we     = idx_ok;
        acc_wdata  = '0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `ASSERT_AT(a_read_gives_result, clk, rst_n, (accept && in_item.opcode == OP_READ) |-> ##2 out_strobe, "read word did not give a result two cycles later")
  `ASSERT_AT(a_clear_runs_full, clk, rst_n, ($fell(busy) && $past(state_r) == ST_CLEAR) |-> ($past(clr_cnt_r) == ADDR_W'(MAX_DIM - 1)), "clearing pass ended early")
  `ASSERT_AT(a_acc_write_states, clk, rst_n, acc_we |-> (state_r == ST_ACC || state_r == ST_RDOUT || state_r == ST_CLEAR), "accumulator written outside a write state")
  `ASSERT_NEVER(a_no_accept_on_result, clk, rst_n, out_strobe && accept, "word accepted while a result is shown")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the sparse matrix-vector multiply-accumulate block.
`timescale 1ns / 1ps
module tb_top;
  import csc_mv_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  // This limit leaves a wide margin above the slowest correct run, including the
  // clearing pass after reset.
  localparam int CYCLE_LIMIT   = 300000;
  // A nonzero word keeps the block busy through ST_VEC, ST_MUL and ST_ACC and a read
  // strobes in ST_RDOUT after ST_RD, so this settle time covers any work still in flight.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS   = 112;

  // Predicts the block's read results from the words it accepts and checks
  // each result strobe against the oldest prediction.
  class matvec_scoreboard;
    bit                      transpose;
    logic signed [VAL_W-1:0] vec_mem [MAX_DIM];
    longint                  acc_mem [MAX_DIM];
    out_item_t               expected_q [$];
    int                      errors;

    function new();
      transpose = 1'b0;
      errors    = 0;
      foreach (acc_mem[i]) begin
        acc_mem[i] = 0;
        vec_mem[i] = '0;
      end
    endfunction

    function void set_mode(bit m);
      transpose = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Applies one accepted word to the model state and queues any result.
    function void note_input(in_item_t it);
      longint    prod;
      longint    sum;
      int        vidx;
      int        dst;
      out_item_t exp_item;
      case (it.opcode)
        OP_LOAD: begin
          if (int'(it.index) < MAX_DIM) vec_mem[it.index] = it.value;
        end
        OP_NZ: begin
          if (int'(it.row) < MAX_DIM && int'(it.col) < MAX_DIM) begin
            if (transpose) begin
              vidx = int'(it.row);
              dst  = int'(it.col);
            end else begin
              vidx = int'(it.col);
              dst  = int'(it.row);
            end
            // Exact Q32.32 product; the arithmetic shift drops the low bits,
            // which rounds towards minus infinity.
            prod = (longint'($signed(it.value)) * longint'(vec_mem[vidx])) >>> FRAC_W;
            sum  = acc_mem[dst] + prod;
            if (sum > longint'(ACC_MAX)) sum = longint'(ACC_MAX);
            if (sum < longint'(ACC_MIN)) sum = longint'(ACC_MIN);
            acc_mem[dst] = sum;
          end
        end
        OP_READ: begin
          exp_item.out_index = it.index;
          exp_item.out_value = '0;
          if (int'(it.index) < MAX_DIM) begin
            exp_item.out_value = acc_mem[it.index][ACC_W-1:0];
            acc_mem[it.index]  = 0;
          end
          expected_q.push_back(exp_item);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_index %0d out_value %0d", got.out_index, got.out_value);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.out_index !== exp_item.out_index) begin
        $error("out_index: expected %0d, actual %0d", exp_item.out_index, got.out_index);
        errors++;
      end
      if (got.out_value !== exp_item.out_value) begin
        $error("out_value: expected %0d, actual %0d", exp_item.out_value, got.out_value);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_wr_en;
  logic      cfg_wdata;

  matvec_scoreboard sb;
  int  cycle_count = 0;
  int  sender_idle_pct = 0;
  int  words_sent = 0;
  bit  cur_mode = 1'b0;
  bit  vec_loaded [MAX_DIM];
  int  loaded_list [$];

  sparse_csc_matvec_accumulate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wdata  (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sparse_csc_matvec_accumulate regression: fail");
      $finish;
    end
  end

  // Results cannot be held off, so every strobe is checked on the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  function automatic in_item_t make_item(op_t op, int idx, int row, int col,
                                         logic [VAL_W-1:0] val);
    in_item_t it;
    it.opcode = op;
    it.index  = idx[FIELD_W-1:0];
    it.row    = row[FIELD_W-1:0];
    it.col    = col[FIELD_W-1:0];
    it.value  = val;
    return it;
  endfunction

  // Mix of extremes, small signed values and fully random words.
  function automatic logic [VAL_W-1:0] rand_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2, 3, 4: begin
        v = 32'($urandom_range(32'h0004_0000));
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Presents one word, with random idle cycles before it, and waits for acceptance.
  // Start is left high so that a following word can go straight after it.
  task automatic send(in_item_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    sb.note_input(item);
    if (item.opcode != OP_NOP) words_sent++;
    if (item.opcode == OP_LOAD && !vec_loaded[item.index]) begin
      vec_loaded[item.index] = 1'b1;
      loaded_list.push_back(int'(item.index));
    end
  endtask

  // Stops sending until every predicted result has been seen and the block is idle.
  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    do @(posedge clk); while (busy);
  endtask

  task automatic write_mode(bit m);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_mode(m);
    cur_mode = m;
  endtask

  // One well-formed sequence: a few vector loads, nonzeros that only use loaded
  // elements, then reads of most of the entries touched, plus occasional noise.
  task automatic send_batch();
    int n_loads;
    int n_nz;
    int vidx;
    int dst;
    int touched [$];
    n_loads = $urandom_range(3);
    repeat (n_loads) begin
      send(make_item(OP_LOAD, $urandom_range(1023), $urandom_range(1023),
                     $urandom_range(1023), rand_value()));
    end
    n_nz = $urandom_range(1, 6);
    repeat (n_nz) begin
      vidx = loaded_list[$urandom_range(loaded_list.size() - 1)];
      if (touched.size() > 0 && $urandom_range(1)) begin
        dst = touched[$urandom_range(touched.size() - 1)];
      end else begin
        dst = $urandom_range(1023);
        touched.push_back(dst);
      end
      if (cur_mode) begin
        send(make_item(OP_NZ, $urandom_range(1023), vidx, dst, rand_value()));
      end else begin
        send(make_item(OP_NZ, $urandom_range(1023), dst, vidx, rand_value()));
      end
    end
    // Skipped reads leave sums behind that later sequences keep adding to.
    foreach (touched[i]) begin
      if ($urandom_range(9) < 7) begin
        send(make_item(OP_READ, touched[i], $urandom_range(1023),
                       $urandom_range(1023), $urandom));
      end
    end
    case ($urandom_range(9))
      0: send(make_item(OP_NOP, $urandom_range(1023), $urandom_range(1023),
                        $urandom_range(1023), $urandom));
      1: send(make_item(OP_READ, $urandom_range(1023), $urandom_range(1023),
                        $urandom_range(1023), $urandom));
      default: begin
      end
    endcase
  endtask

  task automatic run_phase(bit mode, int idle_pct, int n_words);
    int  target;
    bit  paused;
    write_mode(mode);
    sender_idle_pct = idle_pct;
    target = words_sent + n_words;
    paused = 1'b0;
    while (words_sent < target) begin
      send_batch();
      if (!paused && words_sent >= target - n_words / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_wr_en = 1'b0;
    cfg_wdata = 1'b0;
    foreach (vec_loaded[i]) vec_loaded[i] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, matrix times vector first.
    write_mode(1'b0);
    send(make_item(OP_LOAD, 0, 0, 0, 32'h7FFF_FFFF));
    send(make_item(OP_LOAD, 1023, 0, 0, 32'h8000_0000));
    send(make_item(OP_LOAD, 5, 0, 0, 32'h0001_0000));
    send(make_item(OP_LOAD, 6, 0, 0, 32'hFFFF_0000));
    // Most negative times most negative, three times over: positive saturation.
    repeat (3) send(make_item(OP_NZ, 0, 1023, 1023, 32'h8000_0000));
    send(make_item(OP_READ, 1023, 0, 0, 32'h0));
    // A second read of the same entry sees it cleared.
    send(make_item(OP_READ, 1023, 0, 0, 32'h0));
    // Largest times most negative, three times over: negative saturation.
    repeat (3) send(make_item(OP_NZ, 0, 0, 0, 32'h8000_0000));
    send(make_item(OP_READ, 0, 0, 0, 32'h0));
    // Negative products with discarded fraction bits round downwards.
    send(make_item(OP_NZ, 0, 7, 0, 32'hFFFF_FFFF));
    send(make_item(OP_NZ, 0, 7, 6, 32'h0001_8000));
    send(make_item(OP_READ, 7, 0, 0, 32'h0));
    // A no-op with every field bit set must leave everything alone.
    send(make_item(OP_NOP, 1023, 1023, 1023, 32'hFFFF_FFFF));
    send(make_item(OP_READ, 512, 0, 0, 32'h0));
    // Transpose: the row now picks the vector element and the column the sum.
    write_mode(1'b1);
    send(make_item(OP_NZ, 0, 5, 1000, 32'h0002_0000));
    send(make_item(OP_NZ, 0, 1023, 1000, 32'h0000_0001));
    send(make_item(OP_READ, 1000, 0, 0, 32'h0));
    send(make_item(OP_READ, 1023, 0, 0, 32'h0));

    // Random part, through several mode and idling settings.
    run_phase(1'b0, 0, PHASE_WORDS);
    run_phase(1'b1, 87, PHASE_WORDS);
    run_phase(1'b0, 0, PHASE_WORDS);
    run_phase(1'b1, 11, PHASE_WORDS);

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sparse_csc_matvec_accumulate regression: pass");
    end else begin
      $display("sparse_csc_matvec_accumulate regression: fail");
    end
    $finish;
  end

endmodule
